>>> sv/sbrd_pkg.sv
// Shared types, constants and helper functions for the scaled barcode row decoder.
// Used by sbrd_ctrl, sbrd_datapath and scaled_barcode_row_decoder_top.
`default_nettype none

package sbrd_pkg;

  localparam int RUN_COUNT_BITS_DEF = 12;
  localparam int DIGITS_PER_CODE    = 8;
  localparam int NUM_PATTERNS       = 10;
  localparam int IN_TDATA_BITS      = 8;
  localparam int OUT_TDATA_BITS     = 48;

  // Width ratios (first ones : gap : last ones) of digits 0..9
  typedef logic [2:0] ratio_t;
  typedef ratio_t pattern_t [3];
  localparam pattern_t PATTERNS [NUM_PATTERNS] = '{
    '{3'd2, 3'd1, 3'd1}, '{3'd2, 3'd2, 3'd1}, '{3'd1, 3'd2, 3'd2}, '{3'd4, 3'd1, 3'd1},
    '{3'd1, 3'd3, 3'd2}, '{3'd2, 3'd3, 3'd1}, '{3'd1, 3'd1, 3'd4}, '{3'd3, 3'd1, 3'd2},
    '{3'd2, 3'd1, 3'd3}, '{3'd1, 3'd1, 3'd2}
  };

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic bit_step;
    logic close_eor;
    logic clear_all;
    logic div_load;
    logic div_step;
    logic accum;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bits_done;
    logic close_now;
    logic eor;
    logic phase_last;
    logic div_last;
    logic code_done;
    logic out_free;
  } sts_t;

  // {hit, digit}; digit is 0 on a miss
  function automatic logic [4:0] match_digit(input ratio_t qa, input ratio_t qb,
                                             input ratio_t qc);
    logic [4:0] res;
    res = 5'd0;
    for (int k = NUM_PATTERNS - 1; k >= 0; k--) begin
      if (qa == PATTERNS[k][0] && qb == PATTERNS[k][1] && qc == PATTERNS[k][2]) begin
        res = {1'b1, 4'(k)};
      end
    end
    return res;
  endfunction

  function automatic logic [3:0] mod10(input logic [5:0] v);
    logic [5:0] r;
    r = v;
    if (r >= 6'd40) r = r - 6'd40;
    if (r >= 6'd20) r = r - 6'd20;
    if (r >= 6'd10) r = r - 6'd10;
    return r[3:0];
  endfunction

endpackage

`default_nettype wire

>>> sv/sbrd_ctrl.sv
// Sequencing state machine of the barcode row decoder: bit walk, ratio steps, digit commit.
// Depends on sbrd_pkg (cmd_t, sts_t).
`default_nettype none

module sbrd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  sbrd_pkg::sts_t sts,
  output sbrd_pkg::cmd_t cmd
);
  import sbrd_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_BITS     = 6'b000010,
    ST_FINISH   = 6'b000100,
    ST_DIV_LOAD = 6'b001000,
    ST_DIV      = 6'b010000,
    ST_ACCUM    = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd           = '0;
    s_axis_tready = 1'b0;
    state_next    = state;
    case (state)
      ST_IDLE: begin
        s_axis_tready = !rst;
        if (s_axis_tvalid && !rst) begin
          cmd.load_item = 1'b1;
          state_next    = ST_BITS;
        end
      end
      ST_BITS: begin
        if (sts.bits_done) begin
          state_next = ST_FINISH;
        end else begin
          cmd.bit_step = 1'b1;
          if (sts.close_now) state_next = ST_DIV_LOAD;
        end
      end
      ST_FINISH: begin
        // end of row: an open digit in its last ones run still closes
        if (sts.eor && sts.phase_last) begin
          cmd.close_eor = 1'b1;
          state_next    = ST_DIV_LOAD;
        end else begin
          cmd.clear_all = sts.eor;
          state_next    = ST_IDLE;
        end
      end
      ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        // hold while a finished code would overwrite one not yet taken
        if (!sts.code_done || sts.out_free) begin
          cmd.accum  = 1'b1;
          state_next = ST_BITS;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/sbrd_datapath.sv
// Datapath of the barcode row decoder: run counters, scale removal, digit accumulators,
// output register. Depends on sbrd_pkg.
`default_nettype none

module sbrd_datapath #(
  parameter int RUN_COUNT_BITS = sbrd_pkg::RUN_COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sbrd_pkg::cmd_t                      cmd,
  output sbrd_pkg::sts_t                      sts,
  input  logic [3:0]                          hex_nibble,
  input  logic                                end_of_row,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [sbrd_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata
);
  import sbrd_pkg::*;

  localparam int W  = RUN_COUNT_BITS;
  localparam int AW = RUN_COUNT_BITS + 3;     // holds five times the minimum
  localparam logic [W-1:0] WMAX = '1;

  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,
    PH_FIRST = 2'd1,
    PH_GAP   = 2'd2,
    PH_LAST  = 2'd3
  } phase_t;

  logic [3:0]    nib_sh;
  logic          eor;
  logic [2:0]    bit_cnt;
  phase_t        phase;
  logic [W-1:0]  first_w, gap_w, last_w;
  logic [W-1:0]  div_m;
  logic [AW-1:0] acc;
  ratio_t        q_a, q_b, q_c;
  logic [1:0]    step_cnt;
  logic [2:0]    digit_index;
  logic [3:0]    weighted_sum;
  logic [6:0]    plain_sum;
  logic [27:0]   digit_shift;
  logic          bad_digit;
  logic [31:0]   out_code;
  logic          out_ok;
  logic [6:0]    out_total;
  logic          out_err;

  logic          cur_bit;
  logic [W-1:0]  m_min, m_ab;
  logic [AW-1:0] acc_next;
  logic [4:0]    match;
  logic [3:0]    val;
  logic [5:0]    term;
  logic [3:0]    weighted_next;
  logic [6:0]    plain_next;

  assign cur_bit = nib_sh[3];

  assign m_ab     = (first_w < gap_w) ? first_w : gap_w;
  assign m_min    = (last_w < m_ab) ? ((last_w == '0) ? W'(1) : last_w)
                                    : ((m_ab == '0) ? W'(1) : m_ab);
  assign acc_next = acc + AW'(div_m);

  assign match         = match_digit(q_a, q_b, q_c);
  assign val           = match[3:0];
  assign term          = digit_index[0] ? 6'(val) : 6'(val) + {1'b0, val, 1'b0};
  assign weighted_next = mod10(6'(weighted_sum) + term);
  assign plain_next    = plain_sum + 7'(val);

  assign sts.bits_done  = (bit_cnt == 3'd4);
  assign sts.close_now  = (phase == PH_LAST) && !cur_bit;
  assign sts.eor        = eor;
  assign sts.phase_last = (phase == PH_LAST);
  assign sts.div_last   = (step_cnt == 2'd3);
  assign sts.code_done  = (digit_index == 3'(DIGITS_PER_CODE - 1));
  assign sts.out_free   = !m_axis_tvalid || m_axis_tready;

  // run tracking, one bit a step
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_LEAD;
      bit_cnt <= 3'd0;
    end else begin
      if (cmd.load_item) begin
        nib_sh  <= hex_nibble;
        eor     <= end_of_row;
        bit_cnt <= 3'd0;
      end
      if (cmd.bit_step) begin
        nib_sh  <= {nib_sh[2:0], 1'b0};
        bit_cnt <= bit_cnt + 3'd1;
        case (phase)
          PH_LEAD: begin
            if (cur_bit) begin
              phase   <= PH_FIRST;
              first_w <= W'(1);
            end
          end
          PH_FIRST: begin
            if (cur_bit) begin
              first_w <= (first_w == WMAX) ? first_w : first_w + W'(1);
            end else begin
              phase <= PH_GAP;
              gap_w <= W'(1);
            end
          end
          PH_GAP: begin
            if (cur_bit) begin
              phase  <= PH_LAST;
              last_w <= W'(1);
            end else begin
              gap_w <= (gap_w == WMAX) ? gap_w : gap_w + W'(1);
            end
          end
          PH_LAST: begin
            if (cur_bit) last_w <= (last_w == WMAX) ? last_w : last_w + W'(1);
            else         phase  <= PH_LEAD;
          end
          default: phase <= PH_LEAD;
        endcase
      end
      if (cmd.close_eor || cmd.clear_all) phase <= PH_LEAD;
    end
  end

  // quotient by the minimum: count the multiples 2m..5m each width reaches
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      div_m    <= m_min;
      acc      <= AW'(m_min);
      q_a      <= 3'd1;
      q_b      <= 3'd1;
      q_c      <= 3'd1;
      step_cnt <= 2'd0;
    end else if (cmd.div_step) begin
      acc      <= acc_next;
      q_a      <= q_a + 3'(AW'(first_w) >= acc_next);
      q_b      <= q_b + 3'(AW'(gap_w) >= acc_next);
      q_c      <= q_c + 3'(AW'(last_w) >= acc_next);
      step_cnt <= step_cnt + 2'd1;
    end
  end

  // digit accumulators and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_index   <= 3'd0;
      weighted_sum  <= 4'd0;
      plain_sum     <= 7'd0;
      digit_shift   <= 28'd0;
      bad_digit     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cmd.accum && sts.code_done) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready)         m_axis_tvalid <= 1'b0;
      if (cmd.clear_all) begin
        digit_index  <= 3'd0;
        weighted_sum <= 4'd0;
        plain_sum    <= 7'd0;
        digit_shift  <= 28'd0;
        bad_digit    <= 1'b0;
      end else if (cmd.accum) begin
        if (sts.code_done) begin
          out_code     <= {digit_shift, val};
          out_ok       <= (weighted_next == 4'd0);
          out_total    <= plain_next;
          out_err      <= bad_digit | !match[4];
          digit_index  <= 3'd0;
          weighted_sum <= 4'd0;
          plain_sum    <= 7'd0;
          digit_shift  <= 28'd0;
          bad_digit    <= 1'b0;
        end else begin
          digit_index  <= digit_index + 3'd1;
          weighted_sum <= weighted_next;
          plain_sum    <= plain_next;
          digit_shift  <= {digit_shift[23:0], val};
          bad_digit    <= bad_digit | !match[4];
        end
      end
    end
  end

  assign m_axis_tdata = {7'd0, out_err, out_total, out_ok, out_code};

endmodule

`default_nettype wire

>>> sv/scaled_barcode_row_decoder_top.sv
// Scaled barcode row decoder, top level: controller plus datapath.
// Depends on sbrd_pkg, sbrd_ctrl and sbrd_datapath.
`default_nettype none

// Takes one nibble of a scanned row per input word (bit 3 scanned first, tlast on the
// row's last nibble) and emits one word per eight decoded digits: BCD code, check
// result, digit sum and a pattern error flag. Run widths are walked one bit per clock,
// paused while a closed digit is decoded; the next nibble is accepted only after the
// current one is done (accept, four bit steps, a state that sees the bit count done,
// end-of-nibble check). Each digit that closes inside a nibble inserts a load of the
// minimum, four steps of the multiple-compare unit that removes the scale, and the
// digit commit; a digit closed by end of row also takes a second end-of-nibble pass
// after the commit. A finished code waits in the output register; the block only stalls
// if a second code completes before the first is taken. End of row closes a digit in
// its last ones run and then drops any partial code.
module scaled_barcode_row_decoder_top #(
  parameter int RUN_COUNT_BITS = sbrd_pkg::RUN_COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [sbrd_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,  // [3:0] hex_nibble
  input  logic                                s_axis_tlast,  // end_of_row
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [31:0] code_bcd, [32] check_ok, [39:33] digit_total, [40] pattern_error
  output logic [sbrd_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata
);
  import sbrd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sbrd_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  sbrd_datapath #(
    .RUN_COUNT_BITS (RUN_COUNT_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .hex_nibble    (s_axis_tdata[3:0]),
    .end_of_row    (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // a completed code never overwrites a word still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.accum && sts.code_done) |-> sts.out_free)
    else $error("code committed while output word pending");

  // no bit step past the end of the nibble
  a_bit_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.bit_step |-> !sts.bits_done)
    else $error("bit step beyond nibble");

  // digit sum of eight decimal digits stays within 72
  a_total_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[39:33] <= 7'd72))
    else $error("digit total out of range");

  // a new word is never taken while a digit is being decoded
  a_quiet_decode: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_step || cmd.div_load) |-> !s_axis_tready)
    else $error("input ready during digit decode");

endmodule

`default_nettype wire
